FILE: rtl/core/olar_pkg.sv
// Shared types, sizes and codes for the ordered list append/remove unit.
// No dependencies; imported by the top level of the block and by the testbench.
`timescale 1ns / 1ps

package olar_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int VALUE_W  = 32;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [1:0]                mode_t;
    typedef logic [2:0]                status_t;
    typedef logic [CNT_W-1:0]          count_t;
    typedef logic [ADDR_W-1:0]         addr_t;

    localparam mode_t MODE_APPEND = 2'd0;
    localparam mode_t MODE_REMOVE = 2'd1;
    localparam mode_t MODE_READ   = 2'd2;

    localparam status_t ST_DONE      = 3'd0;
    localparam status_t ST_NOT_FOUND = 3'd1;
    localparam status_t ST_FULL      = 3'd2;
    localparam status_t ST_ENTRY     = 3'd3;
    localparam status_t ST_EMPTY     = 3'd4;

endpackage

FILE: rtl/core/olar_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module olar_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // hold read data while no read is issued
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/ordered_list_append_remove_unit.sv
// Top level of the ordered list append/remove unit.
// Depends on olar_pkg and olar_ram.
`timescale 1ns / 1ps

// Keeps an ordered list of up to CAPACITY signed 32-bit values in one RAM,
// head at address 0. One item is worked on at a time; in_ready is high only
// while the unit is idle, and a finished result waits in the output register
// while the next item is taken. Remove scans the RAM one entry per cycle
// through its registered read port and then closes the gap one entry per
// cycle with the read and write ports overlapped. Readout streams one entry
// per cycle from the RAM read port into the output register; the RAM read is
// held while the output stalls. Reset needs no clearing pass: only the state,
// the entry count, the read index and the valid flags are cleared.
module ordered_list_append_remove_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  olar_pkg::mode_t  mode,
    input  olar_pkg::value_t item_value,
    output logic             out_valid,
    input  logic             out_ready,
    output olar_pkg::value_t result_value,
    output olar_pkg::status_t status,
    output logic             last
);

    import olar_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EMIT   = 5'b00010,
        S_SEARCH = 5'b00100,
        S_SHIFT  = 5'b01000,
        S_READ   = 5'b10000
    } state_t;

    state_t  state_reg, state_next;
    count_t  count_reg, count_next;
    count_t  rd_idx_reg, rd_idx_next;
    addr_t   chk_idx_reg, chk_idx_next;
    logic    chk_valid_reg, chk_valid_next;
    value_t  key_reg, key_next;
    status_t pend_reg, pend_next;

    logic    out_valid_reg;
    value_t  result_value_reg;
    status_t status_reg;
    logic    last_reg;

    logic    load_out;
    value_t  load_value;
    status_t load_status;
    logic    load_last;
    logic    slot_free;

    logic    ram_we;
    addr_t   ram_waddr;
    value_t  ram_wdata;
    logic    ram_re;
    addr_t   ram_raddr;
    value_t  ram_rdata;

    olar_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        chk_idx_next   = chk_idx_reg;
        chk_valid_next = chk_valid_reg;
        key_next       = key_reg;
        pend_next      = pend_reg;
        ram_we         = 1'b0;
        ram_waddr      = chk_idx_reg - ADDR_W'(1);
        ram_wdata      = ram_rdata;
        ram_re         = 1'b0;
        ram_raddr      = rd_idx_reg[ADDR_W-1:0];
        load_out       = 1'b0;
        load_value     = '0;
        load_status    = pend_reg;
        load_last      = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    key_next       = item_value;
                    rd_idx_next    = '0;
                    chk_valid_next = 1'b0;
                    case (mode)
                        MODE_APPEND:
                        begin
                            if (count_reg == CNT_W'(CAPACITY))
                            begin
                                pend_next = ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = count_reg[ADDR_W-1:0];
                                ram_wdata  = item_value;
                                count_next = count_reg + CNT_W'(1);
                                pend_next  = ST_DONE;
                            end
                            state_next = S_EMIT;
                        end
                        MODE_REMOVE:
                        begin
                            state_next = S_SEARCH;
                        end
                        MODE_READ:
                        begin
                            if (count_reg == '0)
                            begin
                                pend_next  = ST_EMPTY;
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            pend_next  = ST_DONE;
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end

            S_EMIT:
            begin
                if (slot_free)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_SEARCH:
            begin
                if (chk_valid_reg && (ram_rdata == key_reg))
                begin
                    // match: close up from the entry behind it
                    rd_idx_next    = CNT_W'(chk_idx_reg) + CNT_W'(1);
                    chk_valid_next = 1'b0;
                    state_next     = S_SHIFT;
                end
                else if (rd_idx_reg < count_reg)
                begin
                    ram_re         = 1'b1;
                    chk_idx_next   = rd_idx_reg[ADDR_W-1:0];
                    chk_valid_next = 1'b1;
                    rd_idx_next    = rd_idx_reg + CNT_W'(1);
                end
                else
                begin
                    pend_next  = ST_NOT_FOUND;
                    state_next = S_EMIT;
                end
            end

            S_SHIFT:
            begin
                // write back the entry read last cycle one slot lower;
                // the read address always runs ahead of the write address
                ram_we = chk_valid_reg;
                if (rd_idx_reg < count_reg)
                begin
                    ram_re         = 1'b1;
                    chk_idx_next   = rd_idx_reg[ADDR_W-1:0];
                    chk_valid_next = 1'b1;
                    rd_idx_next    = rd_idx_reg + CNT_W'(1);
                end
                else
                begin
                    chk_valid_next = 1'b0;
                    count_next     = count_reg - CNT_W'(1);
                    pend_next      = ST_DONE;
                    state_next     = S_EMIT;
                end
            end

            S_READ:
            begin
                if (!(chk_valid_reg && !slot_free))
                begin
                    if (chk_valid_reg)
                    begin
                        load_out    = 1'b1;
                        load_value  = ram_rdata;
                        load_status = ST_ENTRY;
                        load_last   = ((CNT_W'(chk_idx_reg) + CNT_W'(1)) == count_reg);
                    end
                    if (rd_idx_reg < count_reg)
                    begin
                        ram_re         = 1'b1;
                        chk_idx_next   = rd_idx_reg[ADDR_W-1:0];
                        chk_valid_next = 1'b1;
                        rd_idx_next    = rd_idx_reg + CNT_W'(1);
                    end
                    else
                    begin
                        chk_valid_next = 1'b0;
                        state_next     = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            chk_valid_reg <= chk_valid_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg <= chk_idx_next;
        key_reg     <= key_next;
        pend_reg    <= pend_next;
        if (load_out)
        begin
            result_value_reg <= load_value;
            status_reg       <= load_status;
            last_reg         <= load_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = result_value_reg;
    assign status       = status_reg;
    assign last         = last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (mode == MODE_APPEND) && (count_reg < CNT_W'(CAPACITY)))
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("append did not grow the list");

    a_no_write_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> !ram_we)
        else $error("store written during readout");

    a_shift_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("read and write hit the same entry");

    a_no_load_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !load_out)
        else $error("result overwritten while stalled");
`endif

endmodule

FILE: test/tb.sv
// Self-checking testbench for ordered_list_append_remove_unit.
// Depends on olar_pkg and the RTL of the unit; it keeps its own list model and
// checks each result against it under random gaps, stalls and a long hold-off.
`timescale 1ns / 1ps

module tb;
    import olar_pkg::*;

    localparam mode_t MODE_UNUSED  = 2'd3;
    localparam int    LIMIT_CYCLES = 400000;

    typedef struct {
        value_t  value;
        status_t status;
        logic    last;
    } reply_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    in_valid = 1'b0;
    logic    in_ready;
    mode_t   mode = MODE_APPEND;
    value_t  item_value = '0;
    logic    out_valid;
    logic    out_ready = 1'b0;
    value_t  result_value;
    status_t status;
    logic    last;

    // list contents as the unit should hold them, head first
    value_t list_model[$];
    reply_t pending_replies[$];
    reply_t next_reply;

    int errors = 0;
    int items_sent = 0;
    int replies_checked = 0;
    int status_seen[0:4];
    int cycle_count = 0;

    int burst_left = 0;
    int gap_max = 4;
    int hold_req = 0;
    int hold_left = 0;
    int stall_style = 0;
    int style_left = 0;

    ordered_list_append_remove_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .item_value   (item_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value),
        .status       (status),
        .last         (last)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("%0t: timeout with %0d results still due", $time, pending_replies.size());
            $display("tb: errors");
            $finish;
        end
    end

    function automatic void add_reply(value_t v, status_t s, logic l);
        reply_t r;
        r.value  = v;
        r.status = s;
        r.last   = l;
        pending_replies.push_back(r);
    endfunction

    // Apply one accepted item to the list model and queue the results it causes.
    function automatic void predict_list_op(mode_t op, value_t v);
        int hit;
        hit = -1;
        case (op)
            MODE_APPEND:
                if (list_model.size() >= CAPACITY)
                    add_reply('0, ST_FULL, 1'b1);
                else
                begin
                    list_model.push_back(v);
                    add_reply('0, ST_DONE, 1'b1);
                end
            MODE_REMOVE:
            begin
                foreach (list_model[i])
                    if (hit < 0 && list_model[i] == v)
                        hit = i;
                if (hit >= 0)
                begin
                    list_model.delete(hit);
                    add_reply('0, ST_DONE, 1'b1);
                end
                else
                    add_reply('0, ST_NOT_FOUND, 1'b1);
            end
            MODE_READ:
                if (list_model.size() == 0)
                    add_reply('0, ST_EMPTY, 1'b1);
                else
                    foreach (list_model[i])
                        add_reply(list_model[i], ST_ENTRY, i == list_model.size() - 1);
            default:
                add_reply('0, ST_DONE, 1'b1);
        endcase
    endfunction

    // Offer one item and hold it until taken; the sender works in bursts.
    task automatic send_item(input mode_t op, input value_t v);
        @(negedge clk);
        in_valid   <= 1'b1;
        mode       <= op;
        item_value <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_list_op(op, v);
        items_sent++;
        if (gap_max > 0 && burst_left == 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(0, gap_max))
                @(negedge clk);
            burst_left = $urandom_range(0, 8);
        end
        else if (burst_left > 0)
            burst_left--;
    endtask

    task automatic wait_drained;
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: a long hold-off on request, otherwise a changing stall pattern.
    always @(negedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            if (style_left == 0)
            begin
                stall_style = $urandom_range(0, 3);
                style_left  = $urandom_range(10, 80);
            end
            style_left--;
            case (stall_style)
                0:       out_ready <= 1'b1;
                1:       out_ready <= $urandom_range(0, 1);
                2:       out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_replies.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: value %0d status %0d last %0b",
                         $time, result_value, status, last);
            end
            else
            begin
                next_reply = pending_replies.pop_front();
                replies_checked++;
                if (status <= ST_EMPTY)
                    status_seen[status]++;
                if (result_value !== next_reply.value)
                begin
                    errors++;
                    $display("%0t: result_value expected %0d actual %0d",
                             $time, next_reply.value, result_value);
                end
                if (status !== next_reply.status)
                begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, next_reply.status, status);
                end
                if (last !== next_reply.last)
                begin
                    errors++;
                    $display("%0t: last expected %0b actual %0b",
                             $time, next_reply.last, last);
                end
            end
        end
    end

    // Half small values so removes and duplicates hit; full range otherwise.
    function automatic value_t random_value();
        if ($urandom_range(0, 1))
            return value_t'($urandom);
        return value_t'($signed($urandom_range(0, 15)) - 8);
    endfunction

    task automatic test_empty_list;
        send_item(MODE_READ, value_t'($urandom));
        send_item(MODE_REMOVE, 32'sd0);
        send_item(MODE_UNUSED, 32'sh7FFF_FFFF);
        wait_drained();
    endtask

    task automatic test_fill_to_full;
        value_t fill_vals[16];
        fill_vals = '{32'sh8000_0000, 32'sd7, -32'sd1, 32'sd0, 32'sh5555_5555,
                      32'shAAAA_AAAA, 32'sd7, 32'sd1, 32'sh7FFF_FFFF, 32'sd3,
                      32'sd7, -32'sd7, 32'sd100, -32'sd100, 32'sd42, 32'sd9};
        foreach (fill_vals[i])
            send_item(MODE_APPEND, fill_vals[i]);
        send_item(MODE_APPEND, 32'sh7FFF_FFFF);
        send_item(MODE_READ, 32'sd0);
        wait_drained();
    endtask

    task automatic test_remove_order;
        send_item(MODE_REMOVE, 32'sh8000_0000);   // head
        send_item(MODE_REMOVE, 32'sd9);           // tail
        send_item(MODE_REMOVE, 32'sd7);           // first of several equal entries
        send_item(MODE_REMOVE, 32'sh5555_5555);   // middle
        send_item(MODE_REMOVE, 32'sd12345);       // no match
        send_item(MODE_READ, -32'sd1);
        wait_drained();
    endtask

    task automatic test_receiver_hold_off;
        int saved_gap;
        saved_gap = gap_max;
        gap_max   = 0;
        hold_req  = 300;
        repeat (20)
            send_item(mode_t'($urandom_range(0, 2)), random_value());
        gap_max = saved_gap;
        wait_drained();
    endtask

    task automatic send_random_item(input int append_pct);
        int     r;
        mode_t  op;
        value_t v;
        r = $urandom_range(0, 99);
        v = random_value();
        if (r < append_pct)
            op = MODE_APPEND;
        else if (r < append_pct + (90 - append_pct) * 6 / 10)
        begin
            op = MODE_REMOVE;
            if (list_model.size() != 0 && $urandom_range(0, 3) != 0)
                v = list_model[$urandom_range(0, list_model.size() - 1)];
        end
        else if (r < 96)
            op = MODE_READ;
        else
            op = MODE_UNUSED;
        send_item(op, v);
    endtask

    task automatic test_random_mix;
        int gaps[3];
        int append_pcts[6];
        gaps        = '{0, 3, 8};
        append_pcts = '{70, 45, 25, 60, 35, 50};
        foreach (append_pcts[p])
        begin
            gap_max = gaps[$urandom_range(0, 2)];
            repeat (28)
                send_random_item(append_pcts[p]);
            if (p == 2)
                wait_drained();
        end
        wait_drained();
    endtask

    initial
    begin
        foreach (status_seen[i])
            status_seen[i] = 0;
        repeat (10)
            @(negedge clk);
        rst_n = 1'b1;

        test_empty_list();
        test_fill_to_full();
        test_remove_order();
        test_receiver_hold_off();
        test_random_mix();

        // let any stray result show up
        repeat (60)
            @(posedge clk);

        $display("summary: %0d items, %0d results checked (done %0d, not found %0d, full %0d)",
                 items_sent, replies_checked, status_seen[ST_DONE],
                 status_seen[ST_NOT_FOUND], status_seen[ST_FULL]);
        $display("summary: %0d list entries read out, %0d empty readouts, %0d mismatches",
                 status_seen[ST_ENTRY], status_seen[ST_EMPTY], errors);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/olar_pkg.sv
rtl/core/olar_ram.sv
rtl/core/ordered_list_append_remove_unit.sv
test/tb.sv
